@@ hw/rtl/bralu_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the bounded rational ALU.
// No dependencies; used by bralu_ctrl, bralu_dp and the top level.
package bralu_pkg;

  localparam int unsigned NUM_W  = 31;
  localparam int unsigned DEN_W  = 30;
  localparam int unsigned PROD_W = 62;  // signed 31 x 31 product
  localparam int unsigned SUM_W  = 63;  // signed sum of two products
  localparam int unsigned MAG_W  = 62;  // magnitude of any sum or product
  localparam int unsigned CNT_W  = $clog2(MAG_W);

  localparam logic [MAG_W-1:0] VALUE_LIMIT = MAG_W'(1000000000);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic sum;
    logic norm;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic gcd_done;
    logic div_last;
  } sts_t;

endpackage

@@ hw/rtl/bralu_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the bounded rational ALU: steps the datapath through
// multiply, normalize, gcd and divide phases. Depends on bralu_pkg.
module bralu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bralu_pkg::cmd_t   cmd_o,
  input  bralu_pkg::sts_t   sts_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_MUL3 = 4'd3;
  localparam logic [3:0] S_SUM  = 4'd4;
  localparam logic [3:0] S_NORM = 4'd5;
  localparam logic [3:0] S_GCD  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_MUL3;
      end
      S_MUL3: begin
        cmd_o.mul3 = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_NORM;
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = sts_i.den_zero ? S_FIN : S_GCD;
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end else begin
          cmd_o.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/bralu_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the bounded rational ALU: shared multiplier, sign fixup,
// binary gcd, dual restoring divider and result register. Uses bralu_pkg.
module bralu_dp (
  input  logic                                clk_i,
  input  bralu_pkg::cmd_t                     cmd_i,
  output bralu_pkg::sts_t                     sts_o,
  input  logic [1:0]                          op_i,
  input  logic signed [bralu_pkg::NUM_W-1:0]  a_num_i,
  input  logic [bralu_pkg::DEN_W-1:0]         a_den_i,
  input  logic signed [bralu_pkg::NUM_W-1:0]  b_num_i,
  input  logic [bralu_pkg::DEN_W-1:0]         b_den_i,
  output logic signed [bralu_pkg::NUM_W-1:0]  r_num_o,
  output logic [bralu_pkg::DEN_W-1:0]         r_den_o,
  output logic [1:0]                          status_o
);

  localparam int unsigned NW = bralu_pkg::NUM_W;
  localparam int unsigned DW = bralu_pkg::DEN_W;
  localparam int unsigned PW = bralu_pkg::PROD_W;
  localparam int unsigned SW = bralu_pkg::SUM_W;
  localparam int unsigned MW = bralu_pkg::MAG_W;
  localparam int unsigned CW = bralu_pkg::CNT_W;

  // operand registers
  logic [1:0]           op_q;
  logic signed [NW-1:0] an_q, bn_q;
  logic [DW-1:0]        ad_q, bd_q;

  // products and raw fraction
  logic signed [PW-1:0] p1_q, p2_q, dr_q;
  logic signed [SW-1:0] nr_q;

  // normalized magnitudes and gcd state
  logic          dz_q, neg_q;
  logic [MW-1:0] mag_q, dm_q;
  logic [MW-1:0] gu_q, gv_q;
  logic [CW-1:0] gk_q;

  // divider
  logic [MW-1:0] qn_q, qd_q, rn_q, rd_q, dvs_q;
  logic [CW-1:0] cnt_q;

  // result register
  logic signed [NW-1:0] r_num_q;
  logic [DW-1:0]        r_den_q;
  logic [1:0]           status_q;

  // ---- multiplier operand select ----
  logic signed [NW-1:0] mx, my;
  logic signed [PW-1:0] prod;
  logic signed [NW-1:0] ad_s, bd_s;

  assign ad_s = $signed({1'b0, ad_q});
  assign bd_s = $signed({1'b0, bd_q});

  always_comb begin
    mx = an_q;
    my = bd_s;
    if (cmd_i.mul1) begin
      mx = an_q;
      my = (op_q == bralu_pkg::OP_MUL) ? bn_q : bd_s;
    end else if (cmd_i.mul2) begin
      mx = bn_q;
      my = ad_s;
    end else if (cmd_i.mul3) begin
      mx = ad_s;
      my = (op_q == bralu_pkg::OP_DIV) ? bn_q : bd_s;
    end
  end

  assign prod = PW'(mx) * PW'(my);

  // ---- raw numerator ----
  logic signed [SW-1:0] sum_d;
  always_comb begin
    unique case (op_q)
      bralu_pkg::OP_ADD: sum_d = SW'(p1_q) + SW'(p2_q);
      bralu_pkg::OP_SUB: sum_d = SW'(p1_q) - SW'(p2_q);
      default:           sum_d = SW'(p1_q);
    endcase
  end

  // ---- sign fixup ----
  logic          d_neg, n_neg;
  logic [SW-1:0] n_abs;
  logic [PW-1:0] d_abs;
  assign d_neg = dr_q[PW-1];
  assign n_neg = nr_q[SW-1];
  assign n_abs = n_neg ? SW'(-nr_q) : SW'(nr_q);
  assign d_abs = d_neg ? PW'(-dr_q) : PW'(dr_q);

  // ---- gcd step ----
  logic          gcd_done;
  logic [MW-1:0] gu_d, gv_d;
  logic [CW-1:0] gk_d;
  assign gcd_done = (gv_q == '0);

  always_comb begin
    gu_d = gu_q;
    gv_d = gv_q;
    gk_d = gk_q;
    priority if (!gu_q[0] && !gv_q[0]) begin
      gu_d = gu_q >> 1;
      gv_d = gv_q >> 1;
      gk_d = gk_q + CW'(1);
    end else if (!gu_q[0]) begin
      gu_d = gu_q >> 1;
    end else if (!gv_q[0]) begin
      gv_d = gv_q >> 1;
    end else if (gu_q > gv_q) begin
      gu_d = gv_q;
      gv_d = gu_q - gv_q;
    end else begin
      gv_d = gv_q - gu_q;
    end
  end

  // ---- restoring divider, two dividends share one divisor ----
  logic [MW:0]   tn, td;
  logic          bn_bit, bd_bit;
  assign tn     = {rn_q, qn_q[MW-1]};
  assign td     = {rd_q, qd_q[MW-1]};
  assign bn_bit = (tn >= {1'b0, dvs_q});
  assign bd_bit = (td >= {1'b0, dvs_q});

  // ---- final result ----
  logic          ovf;
  logic [MW-1:0] qn_neg;
  assign ovf    = (qn_q > bralu_pkg::VALUE_LIMIT) || (qd_q > bralu_pkg::VALUE_LIMIT);
  assign qn_neg = -qn_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
    end
    if (cmd_i.mul1) p1_q <= prod;
    if (cmd_i.mul2) p2_q <= prod;
    if (cmd_i.mul3) dr_q <= prod;
    if (cmd_i.sum)  nr_q <= sum_d;
    if (cmd_i.norm) begin
      dz_q  <= (dr_q == '0);
      neg_q <= (nr_q != '0) && (n_neg ^ d_neg);
      mag_q <= n_abs[MW-1:0];
      dm_q  <= d_abs[MW-1:0];
      // gcd(0, d) = d: start already finished
      if (nr_q == '0) begin
        gu_q <= d_abs[MW-1:0];
        gv_q <= '0;
      end else begin
        gu_q <= n_abs[MW-1:0];
        gv_q <= d_abs[MW-1:0];
      end
      gk_q <= '0;
    end
    if (cmd_i.gcd_step) begin
      gu_q <= gu_d;
      gv_q <= gv_d;
      gk_q <= gk_d;
    end
    if (cmd_i.div_init) begin
      dvs_q <= gu_q << gk_q;
      qn_q  <= mag_q;
      qd_q  <= dm_q;
      rn_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rn_q  <= bn_bit ? MW'(tn - {1'b0, dvs_q}) : tn[MW-1:0];
      rd_q  <= bd_bit ? MW'(td - {1'b0, dvs_q}) : td[MW-1:0];
      qn_q  <= {qn_q[MW-2:0], bn_bit};
      qd_q  <= {qd_q[MW-2:0], bd_bit};
      cnt_q <= cnt_q + CW'(1);
    end
    if (cmd_i.out_load) begin
      if (dz_q) begin
        r_num_q  <= '0;
        r_den_q  <= DW'(1);
        status_q <= bralu_pkg::ST_DIV_ZERO;
      end else if (ovf) begin
        r_num_q  <= '0;
        r_den_q  <= DW'(1);
        status_q <= bralu_pkg::ST_OVERFLOW;
      end else begin
        r_num_q  <= neg_q ? $signed(qn_neg[NW-1:0]) : $signed(qn_q[NW-1:0]);
        r_den_q  <= qd_q[DW-1:0];
        status_q <= bralu_pkg::ST_OK;
      end
    end
  end

  assign sts_o.den_zero = (dr_q == '0);
  assign sts_o.gcd_done = gcd_done;
  assign sts_o.div_last = (cnt_q == CW'(MW - 1));

  assign r_num_o  = r_num_q;
  assign r_den_o  = r_den_q;
  assign status_o = status_q;

endmodule

@@ hw/rtl/bounded_rational_alu.sv @@
`timescale 1ns / 1ps
// Bounded rational ALU, top level: joins bralu_ctrl and bralu_dp.
// Depends on bralu_pkg, bralu_ctrl, bralu_dp.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries op_i and two fractions
//   a_num_i/a_den_i and b_num_i/b_den_i. Output channel (out_valid_o/
//   out_ready_i) returns r_num_o/r_den_o reduced, with status_o
//   (ok, division by zero, magnitude over 1e9; error results are 0/1).
//   One item is in work at a time; in_ready_o is high only when idle.
//   After the input transfer the sequencer runs the multiply, sum and
//   normalize steps, one binary gcd step at a time until done, one step to
//   start the divider, the divider steps and the load into the output
//   register. A zero denominator skips gcd and divide. The next item can
//   be taken in the cycle after the result is loaded.
//   The output register frees the input side: a new item can be taken
//   while a finished result still waits; a stalled receiver holds the next
//   result in the final step until the register is free.
//   Reset clears the sequencer and output valid; the datapath is not reset.
module bounded_rational_alu (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          op_i,
  input  logic signed [bralu_pkg::NUM_W-1:0]  a_num_i,
  input  logic [bralu_pkg::DEN_W-1:0]         a_den_i,
  input  logic signed [bralu_pkg::NUM_W-1:0]  b_num_i,
  input  logic [bralu_pkg::DEN_W-1:0]         b_den_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bralu_pkg::NUM_W-1:0]  r_num_o,
  output logic [bralu_pkg::DEN_W-1:0]         r_den_o,
  output logic [1:0]                          status_o
);

  bralu_pkg::cmd_t cmd;
  bralu_pkg::sts_t sts;

  bralu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bralu_dp u_dp (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .op_i     (op_i),
    .a_num_i  (a_num_i),
    .a_den_i  (a_den_i),
    .b_num_i  (b_num_i),
    .b_den_i  (b_den_i),
    .r_num_o  (r_num_o),
    .r_den_o  (r_den_o),
    .status_o (status_o)
  );

endmodule

@@ hw/rtl/bralu_chk.sv @@
`timescale 1ns / 1ps
// Port-level checker for bounded_rational_alu, attached by bind.
// Depends on bralu_pkg.
module bralu_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [bralu_pkg::NUM_W-1:0]  r_num_o,
  input logic [bralu_pkg::DEN_W-1:0]         r_den_o,
  input logic [1:0]                          status_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // one item in work at a time
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // error results are 0/1
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != bralu_pkg::ST_OK) |-> (r_num_o == '0) && (r_den_o == 1))
    else $error("error result not 0/1");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (r_den_o != '0) &&
      ((status_o == bralu_pkg::ST_OK) || (status_o == bralu_pkg::ST_DIV_ZERO) ||
       (status_o == bralu_pkg::ST_OVERFLOW)))
    else $error("bad result denominator or status");

endmodule

bind bounded_rational_alu bralu_chk u_bralu_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .r_num_o     (r_num_o),
  .r_den_o     (r_den_o),
  .status_o    (status_o)
);

@@ sim/bounded_rational_alu_tb.sv @@
`timescale 1ns / 1ps
// Testbench for bounded_rational_alu: directed table, then random fractions,
// checked against listed or local exact-arithmetic results. Uses bralu_pkg.
module bounded_rational_alu_tb;

  typedef struct {
    bralu_pkg::op_e                     op;
    logic signed [bralu_pkg::NUM_W-1:0] an;
    logic [bralu_pkg::DEN_W-1:0]        ad;
    logic signed [bralu_pkg::NUM_W-1:0] bn;
    logic [bralu_pkg::DEN_W-1:0]        bd;
  } operands_t;

  typedef struct {
    logic signed [bralu_pkg::NUM_W-1:0] num;
    logic [bralu_pkg::DEN_W-1:0]        den;
    bralu_pkg::status_e                 st;
  } fraction_t;

  typedef struct {
    operands_t x;
    bit        typed;
    fraction_t res;
  } table_row_t;

  localparam longint LIMIT = 64'd1000000000;
  localparam int NUM_RANDOM = 690;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = '0;
  logic signed [bralu_pkg::NUM_W-1:0] a_num_i = '0;
  logic [bralu_pkg::DEN_W-1:0] a_den_i = '0;
  logic signed [bralu_pkg::NUM_W-1:0] b_num_i = '0;
  logic [bralu_pkg::DEN_W-1:0] b_den_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [bralu_pkg::NUM_W-1:0] r_num_o;
  logic [bralu_pkg::DEN_W-1:0] r_den_o;
  logic [1:0] status_o;

  fraction_t pending_results[$];
  int errors = 0;
  int sent = 0;
  bit long_hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  bounded_rational_alu dut (.*);

  function automatic longint unsigned euclid_gcd(longint unsigned u, longint unsigned v);
    longint unsigned t;
    while (v != 0) begin
      t = u % v;
      u = v;
      v = t;
    end
    return u;
  endfunction

  function automatic fraction_t rational_result(operands_t x);
    longint an, ad, bn, bd, n, d;
    longint unsigned mag, dm, g;
    bit neg;
    fraction_t r;
    an = longint'(x.an);
    ad = longint'({1'b0, x.ad});
    bn = longint'(x.bn);
    bd = longint'({1'b0, x.bd});
    case (x.op)
      bralu_pkg::OP_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
      bralu_pkg::OP_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
      bralu_pkg::OP_MUL: begin n = an * bn; d = ad * bd; end
      default:           begin n = an * bd; d = ad * bn; end
    endcase
    r.num = '0;
    r.den = bralu_pkg::DEN_W'(1);
    r.st = bralu_pkg::ST_OK;
    if (d == 0) begin
      r.st = bralu_pkg::ST_DIV_ZERO;
    end else begin
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      neg = n < 0;
      mag = neg ? -n : n;
      dm = d;
      g = euclid_gcd(mag, dm);
      mag = mag / g;
      dm = dm / g;
      if (mag > LIMIT || dm > LIMIT) begin
        r.st = bralu_pkg::ST_OVERFLOW;
      end else begin
        r.num = bralu_pkg::NUM_W'(neg ? -mag : mag);
        r.den = bralu_pkg::DEN_W'(dm);
      end
    end
    return r;
  endfunction

  function automatic table_row_t row(bralu_pkg::op_e op, longint an, longint ad, longint bn,
                                     longint bd, bit typed = 0, longint rn = 0,
                                     longint rd = 1,
                                     bralu_pkg::status_e st = bralu_pkg::ST_OK);
    table_row_t t;
    t.x.op = op;
    t.x.an = bralu_pkg::NUM_W'(an);
    t.x.ad = bralu_pkg::DEN_W'(ad);
    t.x.bn = bralu_pkg::NUM_W'(bn);
    t.x.bd = bralu_pkg::DEN_W'(bd);
    t.typed = typed;
    t.res.num = bralu_pkg::NUM_W'(rn);
    t.res.den = bralu_pkg::DEN_W'(rd);
    t.res.st = st;
    return t;
  endfunction

  function automatic operands_t random_operands();
    operands_t x;
    int kind;
    kind = $urandom_range(9);
    x.op = bralu_pkg::op_e'($urandom_range(3));
    if (kind == 0) begin
      // arbitrary bit patterns: unreduced, out of range, zero denominators
      x.an = bralu_pkg::NUM_W'($urandom);
      x.ad = bralu_pkg::DEN_W'($urandom);
      x.bn = bralu_pkg::NUM_W'($urandom);
      x.bd = bralu_pkg::DEN_W'($urandom);
    end else if (kind <= 3) begin
      x.an = bralu_pkg::NUM_W'(longint'($urandom_range(40)) - 20);
      x.ad = bralu_pkg::DEN_W'($urandom_range(1, 30));
      x.bn = bralu_pkg::NUM_W'(longint'($urandom_range(40)) - 20);
      x.bd = bralu_pkg::DEN_W'($urandom_range(1, 30));
    end else if (kind <= 6) begin
      x.an = bralu_pkg::NUM_W'(longint'($urandom_range(200000)) - 100000);
      x.ad = bralu_pkg::DEN_W'($urandom_range(1, 100000));
      x.bn = bralu_pkg::NUM_W'(longint'($urandom_range(200000)) - 100000);
      x.bd = bralu_pkg::DEN_W'($urandom_range(1, 100000));
    end else begin
      x.an = bralu_pkg::NUM_W'(longint'($urandom_range(2000000000)) - LIMIT);
      x.ad = bralu_pkg::DEN_W'($urandom_range(1, 1000000000));
      x.bn = bralu_pkg::NUM_W'(longint'($urandom_range(2000000000)) - LIMIT);
      x.bd = bralu_pkg::DEN_W'($urandom_range(1, 1000000000));
    end
    return x;
  endfunction

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // sender: bursts with random gaps, one pause until drained mid-run.
  // Entered at a clock edge; returns at the edge of the transfer with valid
  // still high, so the next item follows without a gap.
  task automatic send_operands(operands_t x, bit typed, fraction_t res);
    if (sent == 150) long_hold_req <= 1'b1;
    if (sent == 400) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (pending_results.size() != 0) @(posedge clk_i);
    end else if ($urandom_range(5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= x.op; a_num_i <= x.an; a_den_i <= x.ad; b_num_i <= x.bn; b_den_i <= x.bd;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results = {pending_results, (typed ? res : rational_result(x))};
    sent++;
  endtask

  initial begin
    table_row_t directed[$];
    fraction_t none;
    directed = {directed, row(bralu_pkg::OP_ADD, 1, 2, 1, 3, 1, 5, 6)};
    directed = {directed, row(bralu_pkg::OP_SUB, 7, 9, 7, 9, 1, 0, 1)};
    directed = {directed, row(bralu_pkg::OP_MUL, 1000000000, 1, 1, 1000000000, 1, 1, 1)};
    directed = {directed, row(bralu_pkg::OP_DIV, 1, 2, -1, 3, 1, -3, 2)};
    directed = {directed, row(bralu_pkg::OP_DIV, 5, 7, 0, 1, 1, 0, 1,
                              bralu_pkg::ST_DIV_ZERO)};
    directed = {directed, row(bralu_pkg::OP_ADD, 1, 0, 1, 1, 1, 0, 1,
                              bralu_pkg::ST_DIV_ZERO)};
    directed = {directed, row(bralu_pkg::OP_MUL, 1, 1, 1, 0, 1, 0, 1,
                              bralu_pkg::ST_DIV_ZERO)};
    directed = {directed, row(bralu_pkg::OP_MUL, 1000000000, 1, 2, 1, 1, 0, 1,
                              bralu_pkg::ST_OVERFLOW)};
    directed = {directed, row(bralu_pkg::OP_MUL, 1, 1000000000, 1, 3, 1, 0, 1,
                              bralu_pkg::ST_OVERFLOW)};
    directed = {directed, row(bralu_pkg::OP_ADD, 1000000000, 1, -1000000000, 1, 1, 0, 1)};
    directed = {directed, row(bralu_pkg::OP_SUB, -1000000000, 1, 1000000000, 1, 1, 0, 1,
                              bralu_pkg::ST_OVERFLOW)};
    directed = {directed, row(bralu_pkg::OP_ADD, 0, 1, 0, 1000000000, 1, 0, 1)};
    directed = {directed, row(bralu_pkg::OP_DIV, -1000000000, 1000000000, -1, 1, 1, 1, 1)};
    directed = {directed, row(bralu_pkg::OP_ADD, 999999999, 1000000000, 1, 999999999)};
    directed = {directed, row(bralu_pkg::OP_SUB, -999999937, 999999929, 999999893,
                              999999883)};
    directed = {directed, row(bralu_pkg::OP_MUL, -1073741824, 1073741823, -1073741824,
                              1073741823)};
    directed = {directed, row(bralu_pkg::OP_DIV, 1073741823, 1073741823, -1073741824, 1)};
    directed = {directed, row(bralu_pkg::OP_ADD, 6, 4, 9, 6)};
    directed = {directed, row(bralu_pkg::OP_DIV, -12, 18, -8, 30)};
    directed = {directed, row(bralu_pkg::OP_MUL, 536870912, 1, 1, 536870912, 1, 1, 1)};
    none = '{num: '0, den: 1, st: bralu_pkg::ST_OK};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed[i]) send_operands(directed[i].x, directed[i].typed, directed[i].res);
    repeat (NUM_RANDOM) send_operands(random_operands(), 1'b0, none);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: stretches of always-ready and random stalls, one long hold
  initial begin
    int mode;
    bit held;
    held = 0;
    forever begin
      mode = $urandom_range(2);
      repeat ($urandom_range(20, 80)) begin
        @(posedge clk_i);
        if (long_hold_req && !held) begin
          held = 1;
          out_ready_i <= 1'b0;
          repeat (2000) @(posedge clk_i);
        end
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= $urandom_range(3) != 0;
          default: out_ready_i <= $urandom_range(7) == 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    fraction_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer: r_num %0d r_den %0d status %0d",
               r_num_o, r_den_o, status_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (r_num_o !== want.num) begin
          $error("r_num expected %0d actual %0d", want.num, r_num_o);
          errors++;
        end
        if (r_den_o !== want.den) begin
          $error("r_den expected %0d actual %0d", want.den, r_den_o);
          errors++;
        end
        if (status_o !== want.st) begin
          $error("status expected %0d actual %0d", want.st, status_o);
          errors++;
        end
      end
    end
  end

endmodule

@@ filelist.f @@
hw/rtl/bralu_pkg.sv
hw/rtl/bralu_ctrl.sv
hw/rtl/bralu_dp.sv
hw/rtl/bounded_rational_alu.sv
hw/rtl/bralu_chk.sv
sim/bounded_rational_alu_tb.sv
